FILE: src/jpeg_marker_segmenter_macros.svh
// ----------------------------------------------------------------------------
// JPEG marker segmenter assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef JPEG_MARKER_SEGMENTER_MACROS_SVH
`define JPEG_MARKER_SEGMENTER_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define JMS_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("jms assertion failed");

// Next-cycle implication, checked while out of reset.
`define JMS_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("jms assertion failed");

`endif

FILE: src/jms_pkg.sv
// ----------------------------------------------------------------------------
// jms_pkg
// Shared types, constants and marker classification for the marker segmenter.
// ----------------------------------------------------------------------------
package jms_pkg;

    localparam int DEFAULT_POSITION_BITS = 32;
    localparam int OUT_DEPTH             = 4;   // power of two
    localparam int OUT_PTR_BITS          = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_BITS          = $clog2(OUT_DEPTH + 1);

    localparam logic [7:0] MARKER_PREFIX = 8'hFF;
    localparam logic [7:0] MARKER_LO     = 8'hC0;
    localparam logic [7:0] MARKER_HI     = 8'hFE;
    localparam logic [7:0] RST_LO        = 8'hD0;
    localparam logic [7:0] RST_HI        = 8'hD9;
    localparam logic [15:0] LEN_HEADER   = 16'd2;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_TRUNCATED = 2'd1,
        STATUS_NO_CLOSE  = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0]  marker_code;
        logic [31:0] payload_offset;
        logic [31:0] segment_size;
        status_t     segment_status;
        logic        last_of_run;
    } result_t;

    typedef struct packed {
        logic [OUT_CNT_BITS-1:0] count;
        logic                    room;    // space for two more results
    } qstat_t;

    function automatic logic is_rst_class(input logic [7:0] code);
        return (code >= RST_LO) && (code <= RST_HI);
    endfunction

    function automatic logic has_length(input logic [7:0] code);
        return ((code >= 8'hC0) && (code <= 8'hCC)) ||
               ((code >= 8'hDA) && (code <= 8'hDD)) ||
               ((code >= 8'hE0) && (code <= 8'hEF)) ||
               (code == 8'hFE);
    endfunction

endpackage

FILE: src/jms_core.sv
// ----------------------------------------------------------------------------
// jms_core
// Per-byte scan state and result generation; up to two results per byte.
// ----------------------------------------------------------------------------
module jms_core
    import jms_pkg::*;
#(
    parameter int POSITION_BITS = DEFAULT_POSITION_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        fire,
    input  logic [7:0]  data_byte,
    input  logic        end_of_buffer,
    output logic [1:0]  res_valid,
    output result_t     res0,
    output result_t     res1
);

    typedef enum logic [4:0] {
        PH_SCAN    = 5'b00001,
        PH_LEN_HI  = 5'b00010,
        PH_LEN_LO  = 5'b00100,
        PH_SKIP    = 5'b01000,
        PH_TO_NEXT = 5'b10000
    } phase_t;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    phase_t                   phase_reg, phase_next;
    logic                     prev_ff_reg, prev_ff_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [7:0]               pm_reg, pm_next;
    logic [POSITION_BITS-1:0] po_reg, po_next;
    logic [7:0]               len_hi_reg, len_hi_next;
    logic [15:0]              skip_reg, skip_next;

    logic [POSITION_BITS-1:0] pos_inc, mpos, seg_dist;
    logic [15:0]              len, skip_val;
    logic                     a_v, b_v, c_v;
    result_t                  a_r, b_r, c_r;

    always_comb begin
        pos_inc  = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
        mpos     = (pos_reg != '0) ? pos_reg - 1'b1 : '0;
        seg_dist = (mpos >= po_reg) ? mpos - po_reg : '0;
        len      = {len_hi_reg, data_byte};
        skip_val = (len >= LEN_HEADER) ? len - LEN_HEADER : 16'd0;
    end

    always_comb begin
        phase_next   = phase_reg;
        prev_ff_next = prev_ff_reg;
        pos_next     = pos_reg;
        pm_next      = pm_reg;
        po_next      = po_reg;
        len_hi_next  = len_hi_reg;
        skip_next    = skip_reg;
        a_v = 1'b0;
        b_v = 1'b0;
        c_v = 1'b0;
        a_r = '{pm_reg, 32'(po_reg), 32'(seg_dist), STATUS_OK, 1'b0};
        b_r = '{pm_reg, 32'(po_reg), 32'(len), STATUS_OK, 1'b0};
        c_r = '0;

        case (phase_reg)
            PH_LEN_HI: begin
                len_hi_next = data_byte;
                phase_next  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                b_v          = 1'b1;
                skip_next    = skip_val;
                phase_next   = (skip_val != 16'd0) ? PH_SKIP : PH_SCAN;
                prev_ff_next = 1'b0;
            end
            PH_SKIP: begin
                if (skip_reg <= 16'd1) begin
                    skip_next  = 16'd0;
                    phase_next = PH_SCAN;
                end else begin
                    skip_next = skip_reg - 1'b1;
                end
                prev_ff_next = 1'b0;
            end
            default: begin
                // Scanning, with or without an open segment awaiting its close
                phase_next = (phase_reg == PH_TO_NEXT) ? PH_TO_NEXT : PH_SCAN;
                if (prev_ff_reg && (data_byte >= MARKER_LO) && (data_byte <= MARKER_HI)) begin
                    a_v     = (phase_reg == PH_TO_NEXT);
                    pm_next = data_byte;
                    po_next = pos_inc;
                    if (is_rst_class(data_byte)) begin
                        b_v        = 1'b1;
                        b_r        = '{data_byte, 32'(pos_inc), 32'd0, STATUS_OK, 1'b0};
                        phase_next = PH_SCAN;
                    end else if (has_length(data_byte)) begin
                        phase_next = PH_LEN_HI;
                    end else begin
                        phase_next = PH_TO_NEXT;
                    end
                end
                prev_ff_next = (data_byte == MARKER_PREFIX);
            end
        endcase

        if (end_of_buffer) begin
            if ((phase_next == PH_LEN_HI) || (phase_next == PH_LEN_LO)) begin
                c_v = 1'b1;
                c_r = '{pm_next, 32'(po_next), 32'd0, STATUS_TRUNCATED, 1'b0};
            end else if (phase_next == PH_TO_NEXT) begin
                c_v = 1'b1;
                c_r = '{pm_next, 32'(po_next), 32'd0, STATUS_NO_CLOSE, 1'b0};
            end
            // Start the next buffer from scratch
            phase_next   = PH_SCAN;
            prev_ff_next = 1'b0;
            pos_next     = '0;
            pm_next      = '0;
            po_next      = '0;
            len_hi_next  = '0;
            skip_next    = '0;
        end else begin
            pos_next = pos_inc;
        end
    end

    // Pack the candidates in order; flag the final one
    always_comb begin
        res0 = c_r;
        res1 = c_r;
        if (a_v) begin
            res0 = a_r;
            res1 = b_v ? b_r : c_r;
        end else if (b_v) begin
            res0 = b_r;
        end
        res_valid = 2'b00;
        case ({1'b0, a_v} + {1'b0, b_v} + {1'b0, c_v})
            2'd1: begin
                res_valid        = 2'b01;
                res0.last_of_run = 1'b1;
            end
            2'd2: begin
                res_valid        = 2'b11;
                res1.last_of_run = 1'b1;
            end
            default: res_valid = 2'b00;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SCAN;
            prev_ff_reg <= 1'b0;
            pos_reg     <= '0;
            pm_reg      <= '0;
            po_reg      <= '0;
            len_hi_reg  <= '0;
            skip_reg    <= '0;
        end else if (fire) begin
            phase_reg   <= phase_next;
            prev_ff_reg <= prev_ff_next;
            pos_reg     <= pos_next;
            pm_reg      <= pm_next;
            po_reg      <= po_next;
            len_hi_reg  <= len_hi_next;
            skip_reg    <= skip_next;
        end
    end

endmodule

FILE: src/jms_outq.sv
// ----------------------------------------------------------------------------
// jms_outq
// Result queue: takes up to two results per cycle, delivers one per cycle while the reader takes them.
// ----------------------------------------------------------------------------
module jms_outq
    import jms_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] push_valid,
    input  result_t    push0,
    input  result_t    push1,
    input  logic       pop,
    output logic       head_valid,
    output result_t    head,
    output qstat_t     stat
);

    result_t                 mem [OUT_DEPTH];
    logic [OUT_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [OUT_CNT_BITS-1:0] count_reg, count_next;
    logic [OUT_PTR_BITS-1:0] wr_ptr_next, rd_ptr_next;
    logic [1:0]              n_push;

    always_comb begin
        n_push      = {1'b0, push_valid[0]} + {1'b0, push_valid[1]};
        wr_ptr_next = wr_ptr_reg + OUT_PTR_BITS'(n_push);
        rd_ptr_next = rd_ptr_reg + OUT_PTR_BITS'(pop);
        count_next  = count_reg + OUT_CNT_BITS'(n_push) - OUT_CNT_BITS'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push_valid[0]) begin
            mem[wr_ptr_reg] <= push0;
        end
        if (push_valid[1]) begin
            mem[wr_ptr_reg + 1'b1] <= push1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign stat       = '{count: count_reg,
                          room: (count_reg <= OUT_CNT_BITS'(OUT_DEPTH - 2))};

endmodule

FILE: src/jpeg_marker_segmenter.sv
// ----------------------------------------------------------------------------
// jpeg_marker_segmenter
// Scans a JPEG buffer one byte per item and reports every marker segment:
// its code, the offset just past the marker, and its size (length field,
// zero for SOI/EOI/RST, or distance to the next marker). A byte is taken
// every cycle while the four-entry result queue has room for two results;
// each byte is registered, decoded combinationally and its zero to two results
// queued, so throughput is one byte per cycle while the queue has room.
// Bytes that produce two results can stall input only if the result side is
// also stalled. Status 1 marks a truncated length field, status 2 a segment
// left open at the end of the buffer; the position count saturates
// at 2^POSITION_BITS-1.
// ----------------------------------------------------------------------------
`include "jpeg_marker_segmenter_macros.svh"

module jpeg_marker_segmenter
    import jms_pkg::*;
#(
    parameter int POSITION_BITS = DEFAULT_POSITION_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_buffer,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_marker_code,
    output logic [31:0] m_payload_offset,
    output logic [31:0] m_segment_size,
    output logic [1:0]  m_segment_status,
    output logic        m_last_of_run
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eob_reg;
    logic       core_fire;
    logic [1:0] res_valid;
    result_t    res0, res1, head;
    qstat_t     qstat;

    assign core_fire = in_valid_reg && qstat.room;
    assign s_ready   = !in_valid_reg || core_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_eob_reg  <= s_end_of_buffer;
        end
    end

    jms_core #(
        .POSITION_BITS(POSITION_BITS)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fire          (core_fire),
        .data_byte     (in_byte_reg),
        .end_of_buffer (in_eob_reg),
        .res_valid     (res_valid),
        .res0          (res0),
        .res1          (res1)
    );

    jms_outq u_outq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (core_fire ? res_valid : 2'b00),
        .push0      (res0),
        .push1      (res1),
        .pop        (m_valid && m_ready),
        .head_valid (m_valid),
        .head       (head),
        .stat       (qstat)
    );

    assign m_marker_code    = head.marker_code;
    assign m_payload_offset = head.payload_offset;
    assign m_segment_size   = head.segment_size;
    assign m_segment_status = head.segment_status;
    assign m_last_of_run    = head.last_of_run;

    `JMS_ASSERT_IMP(a_queue_bound, 1'b1, qstat.count <= OUT_CNT_BITS'(OUT_DEPTH))
    `JMS_ASSERT_NXT(a_held_item_kept, in_valid_reg && !core_fire, in_valid_reg)
    `JMS_ASSERT_NXT(a_accept_loads, s_valid && s_ready, in_valid_reg)
    `JMS_ASSERT_IMP(a_pair_ordered, res_valid[1], res_valid[0])

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: jpeg_marker_segmenter
// Streams JPEG-like buffers into the segmenter and checks every marker report
// against an in-bench tracker of the marker scan. Buffers are built from
// well-formed segments with random content, plus noise and cut-off endings.
// The position counter is set to a width of 16 bits.
// Both sides stall at random.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import jms_pkg::*;

    localparam int          POS_BITS     = 16;
    localparam logic [63:0] POS_MAX      = (64'd1 << POS_BITS) - 64'd1;
    localparam int          MAX_GAP      = 17;
    localparam int          STALL_LIMIT  = 2000;
    localparam int          RANDOM_ITEMS = 1750;
    localparam int          SETTLE       = 10;

    // marker codes
    localparam logic [7:0] SOF0  = 8'hC0;
    localparam logic [7:0] DHT   = 8'hC4;
    localparam logic [7:0] DAC   = 8'hCC;
    localparam logic [7:0] SOF13 = 8'hCD;
    localparam logic [7:0] SOF15 = 8'hCF;
    localparam logic [7:0] SOI   = 8'hD8;
    localparam logic [7:0] EOI   = 8'hD9;
    localparam logic [7:0] SOS   = 8'hDA;
    localparam logic [7:0] DQT   = 8'hDB;
    localparam logic [7:0] DRI   = 8'hDD;
    localparam logic [7:0] DHP   = 8'hDE;
    localparam logic [7:0] APP0  = 8'hE0;
    localparam logic [7:0] APP15 = 8'hEF;
    localparam logic [7:0] JPG0  = 8'hF0;
    localparam logic [7:0] COM   = 8'hFE;
    localparam logic [7:0] STUFF = 8'h00;

    typedef enum logic [4:0] {
        SEEK_MARKER  = 5'b00001,
        LEN_MSB      = 5'b00010,
        LEN_LSB      = 5'b00100,
        SKIP_PAYLOAD = 5'b01000,
        SEEK_CLOSE   = 5'b10000
    } seg_phase_t;

    typedef struct {
        logic [7:0] data;
        logic       eob;
        int         gap;
        bit         rx_calm;
        bit         drain;
    } feed_item_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_end_of_buffer = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_marker_code;
    logic [31:0] m_payload_offset;
    logic [31:0] m_segment_size;
    logic [1:0]  m_segment_status;
    logic        m_last_of_run;

    feed_item_t  feed [$];
    result_t     segments_due [$];
    result_t     due_seg;
    int          mismatches = 0;
    int          held_cycles = 0;
    int          rx_hold = 0;
    int          idle_cycles = 0;
    bit          tx_calm = 1'b0;
    bit          rx_calm_next = 1'b0;
    bit          rx_calm = 1'b0;

    // marker scan tracker
    seg_phase_t  phase = SEEK_MARKER;
    logic        saw_ff = 1'b0;
    logic [63:0] at_pos = '0;
    logic [7:0]  open_code = '0;
    logic [63:0] open_off = '0;
    logic [7:0]  len_msb = '0;
    logic [15:0] skip_left = '0;

    jpeg_marker_segmenter #(
        .POSITION_BITS(POS_BITS)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_end_of_buffer (s_end_of_buffer),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_marker_code   (m_marker_code),
        .m_payload_offset(m_payload_offset),
        .m_segment_size  (m_segment_size),
        .m_segment_status(m_segment_status),
        .m_last_of_run   (m_last_of_run)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int pick_gap(input bit calm);
        return calm ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    function automatic logic [63:0] step_pos(input logic [63:0] p);
        return (p >= POS_MAX) ? POS_MAX : p + 64'd1;
    endfunction

    function automatic result_t seg_report(input logic [7:0] code, input logic [63:0] off,
                                           input logic [63:0] size, input status_t st);
        result_t r;
        r.marker_code    = code;
        r.payload_offset = off[31:0];
        r.segment_size   = size[31:0];
        r.segment_status = st;
        r.last_of_run    = 1'b0;
        return r;
    endfunction

    task automatic clear_tracking();
        phase     = SEEK_MARKER;
        saw_ff    = 1'b0;
        at_pos    = '0;
        open_code = '0;
        open_off  = '0;
        len_msb   = '0;
        skip_left = '0;
    endtask

    // Advance the scan by one byte and queue the reports it causes.
    task automatic track_byte(input logic [7:0] b, input logic eob);
        logic [63:0] p;
        logic [63:0] mark_at;
        logic [15:0] field_len;
        int          n;
        p = at_pos;
        n = 0;
        case (phase)
            LEN_MSB: begin
                len_msb = b;
                phase   = LEN_LSB;
            end
            LEN_LSB: begin
                field_len = {len_msb, b};
                segments_due.push_back(seg_report(open_code, open_off, 64'(field_len),
                                                  STATUS_OK));
                n++;
                skip_left = (field_len >= LEN_HEADER) ? field_len - LEN_HEADER : 16'd0;
                phase     = (skip_left != 16'd0) ? SKIP_PAYLOAD : SEEK_MARKER;
                saw_ff    = 1'b0;
            end
            SKIP_PAYLOAD: begin
                if (skip_left <= 16'd1) begin
                    skip_left = 16'd0;
                    phase     = SEEK_MARKER;
                end else begin
                    skip_left = skip_left - 16'd1;
                end
                saw_ff = 1'b0;
            end
            default: begin
                if (saw_ff && b >= MARKER_LO && b <= MARKER_HI) begin
                    if (phase == SEEK_CLOSE) begin
                        // closing marker began one byte back; clamp at zero once saturated
                        mark_at = (p != 64'd0) ? p - 64'd1 : 64'd0;
                        segments_due.push_back(seg_report(open_code, open_off,
                            (mark_at >= open_off) ? mark_at - open_off : 64'd0, STATUS_OK));
                        n++;
                    end
                    open_code = b;
                    open_off  = step_pos(p);
                    if (b >= RST_LO && b <= RST_HI) begin
                        segments_due.push_back(seg_report(b, open_off, 64'd0, STATUS_OK));
                        n++;
                        phase = SEEK_MARKER;
                    end else if ((b >= SOF0 && b <= DAC) || (b >= SOS && b <= DRI) ||
                                 (b >= APP0 && b <= APP15) || b == COM) begin
                        phase = LEN_MSB;
                    end else begin
                        phase = SEEK_CLOSE;
                    end
                end
                saw_ff = (b == MARKER_PREFIX);
            end
        endcase
        if (eob) begin
            if (phase == LEN_MSB || phase == LEN_LSB) begin
                segments_due.push_back(seg_report(open_code, open_off, 64'd0,
                                                  STATUS_TRUNCATED));
                n++;
            end else if (phase == SEEK_CLOSE) begin
                segments_due.push_back(seg_report(open_code, open_off, 64'd0,
                                                  STATUS_NO_CLOSE));
                n++;
            end
            clear_tracking();
        end else begin
            at_pos = step_pos(p);
        end
        if (n != 0) begin
            segments_due[segments_due.size() - 1].last_of_run = 1'b1;
        end
    endtask

    task automatic send(input logic [7:0] b, input logic eob);
        feed_item_t it;
        it.data    = b;
        it.eob     = eob;
        it.gap     = pick_gap(tx_calm);
        it.rx_calm = rx_calm_next;
        it.drain   = 1'b0;
        feed.push_back(it);
    endtask

    task automatic hold_until_drained();
        feed_item_t it;
        it.data    = '0;
        it.eob     = 1'b0;
        it.gap     = 0;
        it.rx_calm = rx_calm_next;
        it.drain   = 1'b1;
        feed.push_back(it);
    endtask

    // byte driver
    always @(posedge aclk) begin
        feed_item_t nxt;
        if (!aresetn) begin
            s_valid         <= 1'b0;
            s_data_byte     <= 8'h00;
            s_end_of_buffer <= 1'b0;
            held_cycles = 0;
            clear_tracking();
        end else begin
            if (s_valid && s_ready) begin
                track_byte(s_data_byte, s_end_of_buffer);
            end
            if (!s_valid || s_ready) begin
                if (feed.size() != 0 && feed[0].drain) begin
                    // hold until every pending report has come back
                    if (segments_due.size() == 0) begin
                        feed.delete(0);
                    end
                    s_valid <= 1'b0;
                end else if (feed.size() != 0 && held_cycles < feed[0].gap) begin
                    held_cycles++;
                    s_valid <= 1'b0;
                end else if (feed.size() != 0) begin
                    nxt = feed.pop_front();
                    held_cycles = 0;
                    s_valid         <= 1'b1;
                    s_data_byte     <= nxt.data;
                    s_end_of_buffer <= nxt.eob;
                    rx_calm         <= nxt.rx_calm;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // report monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_hold = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (segments_due.size() == 0) begin
                    $error("unexpected report: marker_code %h, payload_offset %0d",
                           m_marker_code, m_payload_offset);
                    mismatches++;
                end else begin
                    due_seg = segments_due.pop_front();
                    if (m_marker_code !== due_seg.marker_code) begin
                        $error("marker_code: expected %h, got %h",
                               due_seg.marker_code, m_marker_code);
                        mismatches++;
                    end
                    if (m_payload_offset !== due_seg.payload_offset) begin
                        $error("payload_offset: expected %0d, got %0d",
                               due_seg.payload_offset, m_payload_offset);
                        mismatches++;
                    end
                    if (m_segment_size !== due_seg.segment_size) begin
                        $error("segment_size: expected %0d, got %0d",
                               due_seg.segment_size, m_segment_size);
                        mismatches++;
                    end
                    if (m_segment_status !== due_seg.segment_status) begin
                        $error("segment_status: expected %0d, got %0d",
                               due_seg.segment_status, m_segment_status);
                        mismatches++;
                    end
                    if (m_last_of_run !== due_seg.last_of_run) begin
                        $error("last_of_run: expected %0b, got %0b",
                               due_seg.last_of_run, m_last_of_run);
                        mismatches++;
                    end
                end
                rx_hold = pick_gap(rx_calm);
            end else if (rx_hold != 0) begin
                rx_hold--;
            end
            m_ready <= (rx_hold == 0);
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [7:0] frame [$];
        logic [7:0] code;
        logic [7:0] fill;
        int         seg_len;
        int         body;
        int         k;
        int         cut;
        int         random_items;
        bit         ended;
        bit         drained_mid;

        // directed buffer: zero-size markers, short and degenerate lengths,
        // stuffing and fill, a scanned segment closed by a restart marker,
        // then a scanned segment closed by a frame marker cut off at the end
        send(MARKER_PREFIX, 1'b0); send(SOI, 1'b0);
        send(MARKER_PREFIX, 1'b0); send(DQT, 1'b0);
        send(8'h00, 1'b0); send(8'h03, 1'b0); send(8'hAA, 1'b0);
        send(MARKER_PREFIX, 1'b0); send(APP0, 1'b0); send(8'h00, 1'b0); send(8'h00, 1'b0);
        send(MARKER_PREFIX, 1'b0); send(COM, 1'b0); send(8'h00, 1'b0); send(8'h01, 1'b0);
        send(MARKER_PREFIX, 1'b0); send(STUFF, 1'b0);
        send(MARKER_PREFIX, 1'b0); send(MARKER_PREFIX, 1'b0); send(JPG0, 1'b0);
        send(8'h12, 1'b0); send(MARKER_PREFIX, 1'b0); send(RST_LO, 1'b0);
        send(MARKER_PREFIX, 1'b0); send(SOF15, 1'b0); send(8'h34, 1'b0);
        send(MARKER_PREFIX, 1'b0); send(SOF0, 1'b1);
        hold_until_drained();

        random_items = 0;
        drained_mid  = 1'b0;
        while (random_items < RANDOM_ITEMS) begin
            tx_calm      = ($urandom_range(0, 3) == 0);
            rx_calm_next = ($urandom_range(0, 3) == 0);
            frame.delete();
            ended = 1'b0;
            if ($urandom_range(0, 7) != 0) begin
                frame.push_back(MARKER_PREFIX);
                frame.push_back(SOI);
            end
            for (int s = $urandom_range(1, 6); s > 0 && !ended; s--) begin
                case ($urandom_range(0, 9))
                    0, 1: begin
                        frame.push_back(MARKER_PREFIX);
                        frame.push_back(RST_LO + 8'($urandom_range(0, 9)));
                    end
                    2, 3, 4, 5: begin
                        k = $urandom_range(0, 33);
                        if (k < 13)      code = SOF0 + 8'(k);
                        else if (k < 17) code = SOS + 8'(k - 13);
                        else if (k < 33) code = APP0 + 8'(k - 17);
                        else             code = COM;
                        k = $urandom_range(0, 11);
                        if (k == 0)      seg_len = $urandom_range(0, 1);
                        else if (k == 1) seg_len = $urandom_range(0, 65535);
                        else             seg_len = $urandom_range(2, 14);
                        frame.push_back(MARKER_PREFIX);
                        frame.push_back(code);
                        frame.push_back(seg_len[15:8]);
                        frame.push_back(seg_len[7:0]);
                        body = (seg_len > 2) ? seg_len - 2 : 0;
                        if (body > 12) begin
                            // end the buffer while the skip still runs
                            body  = 12;
                            ended = 1'b1;
                        end
                        repeat (body) frame.push_back(8'($urandom_range(0, 255)));
                    end
                    6, 7, 8: begin
                        k = $urandom_range(0, 18);
                        if (k < 3)      code = SOF13 + 8'(k);
                        else if (k < 5) code = DHP + 8'(k - 3);
                        else            code = JPG0 + 8'(k - 5);
                        frame.push_back(MARKER_PREFIX);
                        frame.push_back(code);
                        repeat ($urandom_range(0, 12)) begin
                            fill = 8'($urandom_range(0, 255));
                            frame.push_back(fill);
                            if (fill == MARKER_PREFIX) begin
                                if ($urandom_range(0, 3) == 0) frame.push_back(MARKER_PREFIX);
                                frame.push_back(STUFF);
                            end
                        end
                    end
                    default: begin
                        repeat ($urandom_range(1, 4)) frame.push_back(8'($urandom_range(0, 255)));
                    end
                endcase
            end
            if (!ended && $urandom_range(0, 3) != 0) begin
                frame.push_back(MARKER_PREFIX);
                frame.push_back(EOI);
            end
            if ($urandom_range(0, 4) == 0) begin
                cut = $urandom_range(1, frame.size());
                while (frame.size() > cut) frame.pop_back();
            end
            foreach (frame[i]) send(frame[i], i == frame.size() - 1);
            random_items += frame.size();
            if (!drained_mid && random_items >= RANDOM_ITEMS / 2) begin
                hold_until_drained();
                drained_mid = 1'b1;
            end
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (feed.size() != 0 || s_valid) @(posedge aclk);
        while (segments_due.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0 && segments_due.size() == 0 && !m_valid) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
